/* hdl/kfct_pkg.sv */
package kfct_pkg;

	localparam int ENTRIES    = 16;
	localparam int SLOT_W     = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int KEY_W      = 28;
	localparam int CAP_W      = 5;
	localparam int OUT_SLOT_W = 4;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);
	localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);

	// one write into the key store
	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		logic [KEY_W-1:0]  data;
	} kfct_wr_t;

	// zero acts as one, anything above the slot count saturates
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
		int v;
		v = int'(c);
		if (v == 0)
			v = 1;
		if (v > ENTRIES)
			v = ENTRIES;
		return CNT_W'(v);
	endfunction

endpackage

/* hdl/keyed_fifo_cache_tags.sv */
// Tag store of a small fully associative cache with first-in-first-out
// replacement, keyed by {chapter, section, item_index}.
//
// Input channel: in_valid with the three key fields; the block raises
// in_stall while it works on a word. Output channel: out_valid with hit,
// slot and evicted; the receiver holds back with out_stall.
// Config channel: cfg_valid/cfg_ready carrying capacity_in_use; cfg_ready
// is always high, write only while the block is idle.
//
// One shared 28-bit comparator walks the slots in order through the
// registered read port of the key store, one slot per cycle. A hit ends
// the walk at its slot; a miss walks all ENTRIES slots, then writes the key
// at the insert pointer before the result goes out. The next word is not
// taken before the result reaches the output register, and can be taken in
// the cycle after.
//
// Reset clears all valid bits, the insert pointer and the output valid bit and
// sets capacity to 16; the key store itself is not cleared. A stalled result
// holds in the output register while the next word is already looked up;
// the block waits in its final step only if both would collide.
module keyed_fifo_cache_tags
	import kfct_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CAP_W-1:0]      capacity_in_use,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            chapter,
	input  logic [7:0]            section,
	input  logic [11:0]           item_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic [OUT_SLOT_W-1:0] slot,
	output logic                  evicted
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_INSERT, ST_DONE} state_t;

	state_t              state_q;
	logic [CAP_W-1:0]    cap_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [SLOT_W-1:0]   ptr_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [KEY_W-1:0]    key_q;
	logic                rd_valid_s1;
	logic [SLOT_W-1:0]   addr_s1;
	logic                vld_s1;
	logic                res_hit_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                res_evict_q;
	logic                out_valid_q;
	logic                out_hit_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_evict_q;

	logic [CNT_W-1:0]    cap;
	logic [SLOT_W-1:0]   target;
	logic [SLOT_W-1:0]   ptr_next;
	logic [KEY_W-1:0]    rd_key;
	logic                match;
	kfct_wr_t            wr;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;
	assign slot      = OUT_SLOT_W'(out_slot_q);
	assign evicted   = out_evict_q;

	// wrap the pointer if capacity was lowered underneath it
	assign cap      = eff_cap(cap_q);
	assign target   = (CNT_W'(ptr_q) >= cap) ? '0 : ptr_q;
	assign ptr_next = ((CNT_W'(target) + CNT_W'(1)) >= cap) ? '0 : target + SLOT_W'(1);

	assign wr.we   = (state_q == ST_INSERT);
	assign wr.addr = target;
	assign wr.data = key_q;

	kfct_key_mem u_mem (
		.clk   (clk),
		.wr    (wr),
		.raddr (idx_q),
		.rdata (rd_key)
	);

	kfct_match u_match (
		.vld    (vld_s1),
		.stored (rd_key),
		.key    (key_q),
		.match  (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			valid_q     <= '0;
			ptr_q       <= '0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				cap_q <= capacity_in_use;

			// read port pipeline: address and valid bit are registered to line up with the registered read data
			rd_valid_s1 <= (state_q == ST_SCAN);
			addr_s1     <= idx_q;
			vld_s1      <= valid_q[idx_q];

			// drop a taken result unless the final step refills the register
			if (out_valid_q && !out_stall && state_q != ST_DONE)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q   <= {chapter, section, item_index};
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q != LAST_SLOT)
						idx_q <= idx_q + SLOT_W'(1);
					// first match in ascending order wins
					if (rd_valid_s1 && match) begin
						res_hit_q   <= 1'b1;
						res_slot_q  <= addr_s1;
						res_evict_q <= 1'b0;
						state_q     <= ST_DONE;
					end else if (rd_valid_s1 && addr_s1 == LAST_SLOT) begin
						state_q <= ST_INSERT;
					end
				end
				ST_INSERT: begin
					res_hit_q       <= 1'b0;
					res_slot_q      <= target;
					res_evict_q     <= valid_q[target];
					valid_q[target] <= 1'b1;
					ptr_q           <= ptr_next;
					state_q         <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_hit_q   <= res_hit_q;
						out_slot_q  <= res_slot_q;
						out_evict_q <= res_evict_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hdl/kfct_key_mem.sv */
module kfct_key_mem
	import kfct_pkg::*;
(
	input  logic              clk,
	input  kfct_wr_t          wr,
	input  logic [SLOT_W-1:0] raddr,
	output logic [KEY_W-1:0]  rdata
);

	logic [KEY_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.we)
			mem[wr.addr] <= wr.data;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hdl/kfct_match.sv */
module kfct_match
	import kfct_pkg::*;
(
	input  logic             vld,
	input  logic [KEY_W-1:0] stored,
	input  logic [KEY_W-1:0] key,
	output logic             match
);

	// only a valid entry may hit
	assign match = vld && (stored == key);

endmodule

/* hdl/kfct_chk.sv */
module kfct_chk
	import kfct_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  hit,
	input logic [OUT_SLOT_W-1:0] slot,
	input logic                  evicted
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({hit, slot, evicted}))
		else $error("stalled result changed");

	// hits never evict
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted))
		else $error("hit reported with eviction");

	// busy after accepting a word, through the start of the lookup
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
		else $error("new word taken during lookup");

	// no fresh result while the block is still walking the slots
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid ##1 !out_valid)
		else $error("result appeared too early");

endmodule

bind keyed_fifo_cache_tags kfct_chk u_chk (.*);
